FILE: rtl/wdp_pkg.sv
package wdp_pkg;

    localparam int NIBBLE_W    = 4;
    localparam int NIB_COUNT   = 8;
    localparam int WORD_W      = NIBBLE_W * NIB_COUNT;
    localparam int SLOT_W      = 6;
    localparam int ALLOWED_W   = 64;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 7;
    localparam int LENGTH_W    = 4;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 1;

    localparam logic CMD_LOAD      = 1'b0;
    localparam logic CMD_PROPAGATE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_WORD_COUNT    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LENGTH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_FIX      = 2'd0,
        STATUS_SUBSUMED = 2'd1,
        STATUS_FAILED   = 2'd2
    } status_t;

    // one dictionary word moving down the row of position cells
    typedef struct packed {
        logic              valid;
        logic              act;
        logic [SLOT_W-1:0] idx;
        logic [WORD_W-1:0] word;
        logic              imp;
        logic              cert;
    } chain_t;

    // running classification of the scanned words
    typedef struct packed {
        logic [1:0]           n_allowed;
        logic [SLOT_W-1:0]    one_idx;
        logic                 any_cert;
        logic [1:0]           n_poss;
        logic [SLOT_W-1:0]    poss_idx;
        logic [ALLOWED_W-1:0] impossible;
        logic [WORD_W-1:0]    word_union;
    } tally_t;

endpackage

FILE: rtl/wdp_req_if.sv
interface wdp_req_if;

    logic                                valid;
    logic                                ready;
    logic                                command;
    logic [wdp_pkg::SLOT_W-1:0]          word_slot;
    logic [wdp_pkg::WORD_W-1:0]          word_masks;
    logic [wdp_pkg::WORD_W-1:0]          window_domains;
    logic [wdp_pkg::ALLOWED_W-1:0]       allowed_words;

    modport source (
        output valid, command, word_slot, word_masks, window_domains, allowed_words,
        input  ready
    );

    modport sink (
        input  valid, command, word_slot, word_masks, window_domains, allowed_words,
        output ready
    );

endinterface

FILE: rtl/wdp_rsp_if.sv
interface wdp_rsp_if;

    logic                                valid;
    logic                                ready;
    logic [wdp_pkg::STATUS_W-1:0]        status;
    logic [wdp_pkg::WORD_W-1:0]          new_domains;
    logic [wdp_pkg::ALLOWED_W-1:0]       new_allowed;

    modport source (
        output valid, status, new_domains, new_allowed,
        input  ready
    );

    modport sink (
        input  valid, status, new_domains, new_allowed,
        output ready
    );

endinterface

FILE: rtl/word_dictionary_propagator.sv
// channel  side  handshake      payload
// req      in    valid/ready    command, word_slot, word_masks, window_domains, allowed_words
// rsp      out   valid/ready    status, new_domains, new_allowed
// cfg      in    cfg_write      cfg_index, cfg_data
//
// a load item writes one dictionary entry, and none when word_slot is not below MAX_WORDS
// a propagate item scans the words in use through the cell row, then fetches the one word
// again when the window is fixed to one word; it skips the scan when no word is in use
// the dictionary memory gives one word per cycle into the row of position cells
// reset clears control state only; dictionary entries are undefined until loaded
// a finished item waits in the output register while the next item is taken in, and the
// next result holds the input off until that one is taken
module word_dictionary_propagator #(
    parameter int MAX_WORDS  = 64,
    parameter int MAX_WINDOW = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    wdp_req_if.sink                            req,
    wdp_rsp_if.source                          rsp,
    input  logic                               cfg_write,
    input  logic [wdp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wdp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import wdp_pkg::*;

    localparam int IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_W = $clog2(MAX_WORDS + 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_DRAIN  = 6'b000100,
        ST_FETCH  = 6'b001000,
        ST_FIX    = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [COUNT_W-1:0]     word_count_reg;
    logic [COUNT_W-1:0]     word_count_next;
    logic [LENGTH_W-1:0]    window_length_reg;
    logic [LENGTH_W-1:0]    window_length_next;
    logic [CNT_W-1:0]       scan_cnt_reg;
    logic [CNT_W-1:0]       scan_cnt_next;
    logic [CNT_W-1:0]       wc_reg;
    logic [CNT_W-1:0]       wc_next;
    logic [LENGTH_W-1:0]    len_reg;
    logic [LENGTH_W-1:0]    len_next;
    logic [WORD_W-1:0]      dom_reg;
    logic [WORD_W-1:0]      dom_next;
    logic [ALLOWED_W-1:0]   active_reg;
    logic [ALLOWED_W-1:0]   active_next;
    logic [SLOT_W-1:0]      fix_idx_reg;
    logic [SLOT_W-1:0]      fix_idx_next;
    logic                   rd_valid_reg;
    logic                   rd_valid_next;
    logic [SLOT_W-1:0]      rd_idx_reg;
    logic [SLOT_W-1:0]      rd_idx_next;
    logic [WORD_W-1:0]      rdata_reg;
    status_t                res_status_reg;
    status_t                res_status_next;
    logic [WORD_W-1:0]      res_domains_reg;
    logic [WORD_W-1:0]      res_domains_next;
    logic [ALLOWED_W-1:0]   res_allowed_reg;
    logic [ALLOWED_W-1:0]   res_allowed_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    status_t                out_status_reg;
    status_t                out_status_next;
    logic [WORD_W-1:0]      out_domains_reg;
    logic [WORD_W-1:0]      out_domains_next;
    logic [ALLOWED_W-1:0]   out_allowed_reg;
    logic [ALLOWED_W-1:0]   out_allowed_next;

    logic [WORD_W-1:0]      dict_mem [MAX_WORDS];

    logic                   accept;
    logic                   start;
    logic                   dict_we;
    logic [IDX_W-1:0]       raddr;
    logic [CNT_W-1:0]       wc_clamp;
    logic [LENGTH_W-1:0]    len_clamp;
    logic [ALLOWED_W-1:0]   used_mask;
    logic [WORD_W-1:0]      keep_mask;
    logic                   pipe_busy;
    logic                   out_free;
    logic                   fix_ok;
    logic [WORD_W-1:0]      fix_domains;
    logic [MAX_WINDOW-1:0]  cell_enable;
    chain_t                 chain [MAX_WINDOW+1];
    tally_t                 tally_q;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign start     = accept && (req.command == CMD_PROPAGATE);
    assign dict_we   = accept && (req.command == CMD_LOAD) && (req.word_slot < MAX_WORDS);
    assign raddr     = (state_reg == ST_SCAN) ? scan_cnt_reg[IDX_W-1:0]
                                              : fix_idx_reg[IDX_W-1:0];
    assign out_free  = !out_valid_reg || rsp.ready;

    assign wc_clamp  = (word_count_reg > MAX_WORDS) ? CNT_W'(MAX_WORDS)
                                                    : CNT_W'(word_count_reg);
    assign len_clamp = (window_length_reg > MAX_WINDOW) ? LENGTH_W'(MAX_WINDOW)
                                                        : window_length_reg;

    always_comb
    begin
        for (int i = 0; i < ALLOWED_W; i++)
        begin
            used_mask[i] = (i < int'(wc_clamp));
        end
        for (int i = 0; i < NIB_COUNT; i++)
        begin
            keep_mask[NIBBLE_W*i +: NIBBLE_W] = {NIBBLE_W{LENGTH_W'(i) < len_reg}};
        end
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            cell_enable[k] = (LENGTH_W'(k) < len_clamp);
        end
    end

    // dictionary memory, registered read
    always_ff @(posedge clk)
    begin
        if (dict_we)
        begin
            dict_mem[req.word_slot[IDX_W-1:0]] <= req.word_masks;
        end
        rdata_reg <= dict_mem[raddr];
    end

    // head of the cell row
    always_comb
    begin
        chain[0].valid = rd_valid_reg;
        chain[0].act   = active_reg[rd_idx_reg];
        chain[0].idx   = rd_idx_reg;
        chain[0].word  = rdata_reg;
        chain[0].imp   = 1'b0;
        chain[0].cert  = 1'b1;
    end

    for (genvar k = 0; k < MAX_WINDOW; k++)
    begin : g_cell
        wdp_cell #(
            .POS (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (start),
            .dom_nibble (req.window_domains[NIBBLE_W*k +: NIBBLE_W]),
            .enable     (cell_enable[k]),
            .prev_stage (chain[k]),
            .stage_out  (chain[k+1])
        );
    end

    wdp_tally u_tally (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (start),
        .last_stage (chain[MAX_WINDOW]),
        .tally      (tally_q)
    );

    always_comb
    begin
        pipe_busy = rd_valid_reg;
        for (int k = 1; k <= MAX_WINDOW; k++)
        begin
            pipe_busy = pipe_busy | chain[k].valid;
        end
    end

    // fix each position inside the window to the lowest set bit of the fetched word
    always_comb
    begin
        logic [NIBBLE_W-1:0] wn;
        logic [NIBBLE_W-1:0] low;
        fix_ok      = 1'b1;
        fix_domains = dom_reg;
        for (int i = 0; i < NIB_COUNT; i++)
        begin
            wn  = rdata_reg[NIBBLE_W*i +: NIBBLE_W];
            low = wn & (~wn + NIBBLE_W'(1));
            if (LENGTH_W'(i) < len_reg)
            begin
                if ((low == '0) || ((dom_reg[NIBBLE_W*i +: NIBBLE_W] & low) == '0))
                begin
                    fix_ok = 1'b0;
                end
                fix_domains[NIBBLE_W*i +: NIBBLE_W] = low;
            end
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        word_count_next    = word_count_reg;
        window_length_next = window_length_reg;
        scan_cnt_next      = scan_cnt_reg;
        wc_next            = wc_reg;
        len_next           = len_reg;
        dom_next           = dom_reg;
        active_next        = active_reg;
        fix_idx_next       = fix_idx_reg;
        rd_valid_next      = 1'b0;
        rd_idx_next        = rd_idx_reg;
        res_status_next    = res_status_reg;
        res_domains_next   = res_domains_reg;
        res_allowed_next   = res_allowed_reg;
        out_valid_next     = out_valid_reg && !rsp.ready;
        out_status_next    = out_status_reg;
        out_domains_next   = out_domains_reg;
        out_allowed_next   = out_allowed_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_WORD_COUNT:    word_count_next    = cfg_data[COUNT_W-1:0];
                CFG_WINDOW_LENGTH: window_length_next = cfg_data[LENGTH_W-1:0];
                default:           ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    wc_next       = wc_clamp;
                    len_next      = len_clamp;
                    dom_next      = req.window_domains;
                    active_next   = req.allowed_words & used_mask;
                    scan_cnt_next = '0;
                    state_next    = (wc_clamp == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_valid_next = 1'b1;
                rd_idx_next   = SLOT_W'(scan_cnt_reg[IDX_W-1:0]);
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (scan_cnt_reg + CNT_W'(1) == wc_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_FINISH;
                    if (tally_q.n_allowed == 2'd1)
                    begin
                        fix_idx_next = tally_q.one_idx;
                        state_next   = ST_FETCH;
                    end
                    else if (tally_q.any_cert)
                    begin
                        res_status_next  = STATUS_SUBSUMED;
                        res_domains_next = dom_reg;
                        res_allowed_next = active_reg;
                    end
                    else if (tally_q.n_poss == 2'd1)
                    begin
                        fix_idx_next = tally_q.poss_idx;
                        state_next   = ST_FETCH;
                    end
                    else if (tally_q.n_poss == 2'd0)
                    begin
                        res_status_next  = STATUS_FAILED;
                        res_domains_next = '0;
                        res_allowed_next = '0;
                    end
                    else
                    begin
                        res_status_next  = STATUS_FIX;
                        res_domains_next = (dom_reg & ~keep_mask)
                                         | (dom_reg & tally_q.word_union & keep_mask);
                        res_allowed_next = active_reg & ~tally_q.impossible;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                if (fix_ok)
                begin
                    res_status_next  = STATUS_SUBSUMED;
                    res_domains_next = fix_domains;
                    res_allowed_next = active_reg;
                end
                else
                begin
                    res_status_next  = STATUS_FAILED;
                    res_domains_next = '0;
                    res_allowed_next = '0;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_domains_next = res_domains_reg;
                    out_allowed_next = res_allowed_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            word_count_reg    <= COUNT_W'(1);
            window_length_reg <= LENGTH_W'(8);
            scan_cnt_reg      <= '0;
            wc_reg            <= '0;
            len_reg           <= '0;
            rd_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            word_count_reg    <= word_count_next;
            window_length_reg <= window_length_next;
            scan_cnt_reg      <= scan_cnt_next;
            wc_reg            <= wc_next;
            len_reg           <= len_next;
            rd_valid_reg      <= rd_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dom_reg         <= dom_next;
        active_reg      <= active_next;
        fix_idx_reg     <= fix_idx_next;
        rd_idx_reg      <= rd_idx_next;
        res_status_reg  <= res_status_next;
        res_domains_reg <= res_domains_next;
        res_allowed_reg <= res_allowed_next;
        out_status_reg  <= out_status_next;
        out_domains_reg <= out_domains_next;
        out_allowed_reg <= out_allowed_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.new_domains = out_domains_reg;
    assign rsp.new_allowed = out_allowed_reg;

    a_idle_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pipe_busy)
        else $error("cell row still holds words while idle");

    a_failed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STATUS_FAILED)
        |-> (rsp.new_domains == '0 && rsp.new_allowed == '0))
        else $error("failed result carries nonzero payload");

    a_tally_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (tally_q.n_allowed == 2'd0) |-> (tally_q.n_poss == 2'd0 && !tally_q.any_cert))
        else $error("classified words without any allowed word");

    a_start_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.command == CMD_PROPAGATE)
        |=> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("propagate item did not start a scan");

endmodule

FILE: rtl/wdp_cell.sv
module wdp_cell #(
    parameter int POS = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic [wdp_pkg::NIBBLE_W-1:0]   dom_nibble,
    input  logic                           enable,
    input  wdp_pkg::chain_t                prev_stage,
    output wdp_pkg::chain_t                stage_out
);
    import wdp_pkg::*;

    logic [NIBBLE_W-1:0] dom_reg;
    logic [NIBBLE_W-1:0] dom_next;
    logic                enable_reg;
    logic                enable_next;
    chain_t              stage_reg;
    chain_t              stage_next;
    logic [NIBBLE_W-1:0] word_nibble;

    assign word_nibble = prev_stage.word[NIBBLE_W*POS +: NIBBLE_W];

    always_comb
    begin
        dom_next    = dom_reg;
        enable_next = enable_reg;
        if (load)
        begin
            dom_next    = dom_nibble;
            enable_next = enable;
        end
    end

    always_comb
    begin
        stage_next = prev_stage;
        if (prev_stage.valid && enable_reg)
        begin
            if ((word_nibble & dom_reg) == '0)
            begin
                stage_next.imp = 1'b1;
            end
            // domain not inside the word mask at this position
            if ((dom_reg & ~word_nibble) != '0)
            begin
                stage_next.cert = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg  <= '0;
            enable_reg <= 1'b0;
        end
        else
        begin
            stage_reg  <= stage_next;
            enable_reg <= enable_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dom_reg <= dom_next;
    end

    assign stage_out = stage_reg;

endmodule

FILE: rtl/wdp_tally.sv
module wdp_tally (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  wdp_pkg::chain_t   last_stage,
    output wdp_pkg::tally_t   tally
);
    import wdp_pkg::*;

    tally_t tally_reg;
    tally_t tally_next;

    always_comb
    begin
        tally_next = tally_reg;
        if (clear)
        begin
            tally_next = '0;
        end
        else if (last_stage.valid && last_stage.act)
        begin
            if (tally_reg.n_allowed != 2'd2)
            begin
                tally_next.n_allowed = tally_reg.n_allowed + 2'd1;
            end
            tally_next.one_idx = last_stage.idx;
            if (last_stage.imp)
            begin
                tally_next.impossible[last_stage.idx] = 1'b1;
            end
            else
            begin
                tally_next.word_union = tally_reg.word_union | last_stage.word;
                if (last_stage.cert)
                begin
                    tally_next.any_cert = 1'b1;
                end
                else
                begin
                    // saturates at two, only zero / one / many matter
                    if (tally_reg.n_poss != 2'd2)
                    begin
                        tally_next.n_poss = tally_reg.n_poss + 2'd1;
                    end
                    tally_next.poss_idx = last_stage.idx;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg <= '0;
        end
        else
        begin
            tally_reg <= tally_next;
        end
    end

    assign tally = tally_reg;

endmodule
